// File: rtl/core/gep_pkg.sv
// Shared types and constants for the gated envelope panner.
package gep_pkg;

  // Default widths for samples and phase counters.
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned COUNT_WIDTH_DEF  = 24;

  // Fixed field widths.
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned PAN_W     = 18;
  localparam int unsigned LEN_W     = 24;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_W    = 16;

  // Q16 constants.
  localparam logic [GAIN_W-1:0] UNITY    = 17'h10000;
  localparam logic [PAN_W-1:0]  PAN_MAX  = 18'h20000;
  localparam logic [FRAC_W-1:0] HALF_LSB = 16'h8000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_RECIP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLATEAU_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALLEY_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_RIGHT   = 3'd6;

  typedef enum logic [1:0] {
    PH_SLOPE_IN  = 2'd0,
    PH_PLATEAU   = 2'd1,
    PH_SLOPE_OUT = 2'd2,
    PH_VALLEY    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    GM_SLOPE,
    GM_UNITY,
    GM_FLOOR
  } gain_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_GAIN,
    ST_MUL4,
    ST_FINISH
  } ctrl_state_e;

  // Register file contents, already clamped to range.
  typedef struct packed {
    logic [LEN_W-1:0]  slope_length;
    logic [GAIN_W-1:0] slope_recip;
    logic [LEN_W-1:0]  plateau_length;
    logic [LEN_W-1:0]  valley_length;
    logic [GAIN_W-1:0] floor_gain;
    logic [PAN_W-1:0]  pan_left;
    logic [PAN_W-1:0]  pan_right;
  } cfg_t;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic mul3;
    logic gain;
    logic mul4;
    logic finish;
  } dp_cmd_t;

endpackage

// File: rtl/core/gep_regs.sv
// Configuration register file with range clamping on write.
module gep_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gep_pkg::CFG_W-1:0]        cfg_data_i,
  output gep_pkg::cfg_t                    cfg_o
);
  import gep_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [GAIN_W-1:0] data_gain;
  logic [PAN_W-1:0]  data_pan;

  always_comb begin
    data_gain = cfg_data_i[GAIN_W-1:0];
    data_pan  = cfg_data_i[PAN_W-1:0];
    cfg_d     = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLOPE_LEN:   cfg_d.slope_length   = cfg_data_i[LEN_W-1:0];
        REG_SLOPE_RECIP: cfg_d.slope_recip    = (data_gain > UNITY) ? UNITY : data_gain;
        REG_PLATEAU_LEN: cfg_d.plateau_length = cfg_data_i[LEN_W-1:0];
        REG_VALLEY_LEN:  cfg_d.valley_length  = cfg_data_i[LEN_W-1:0];
        REG_FLOOR_GAIN:  cfg_d.floor_gain     = (data_gain > UNITY) ? UNITY : data_gain;
        REG_PAN_LEFT:    cfg_d.pan_left       = (data_pan > PAN_MAX) ? PAN_MAX : data_pan;
        REG_PAN_RIGHT:   cfg_d.pan_right      = (data_pan > PAN_MAX) ? PAN_MAX : data_pan;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_length   <= '0;
      cfg_q.slope_recip    <= '0;
      cfg_q.plateau_length <= LEN_W'(1);
      cfg_q.valley_length  <= LEN_W'(1);
      cfg_q.floor_gain     <= '0;
      cfg_q.pan_left       <= PAN_W'(UNITY);
      cfg_q.pan_right      <= PAN_W'(UNITY);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/gep_ctrl.sv
// Step sequencer and output handshake for the gated envelope panner.
module gep_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gep_pkg::dp_cmd_t cmd_o
);
  import gep_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && out_free);
    accept     = in_valid_i && in_ready_o;
    cmd_o      = '0;
    cmd_o.capture = accept;
    state_d    = state_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = ST_MUL4;
      end
      ST_MUL4: begin
        cmd_o.mul4 = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = accept ? ST_MUL1 : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/gep_dp.sv
// Envelope phase counter, two shared multipliers and the output register.
module gep_dp #(
  parameter int unsigned SAMPLE_WIDTH = gep_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = gep_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gep_pkg::cfg_t                  cfg_i,
  input  gep_pkg::dp_cmd_t               cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] right_out_o,
  output logic [gep_pkg::GAIN_W-1:0]     envelope_gain_o
);
  import gep_pkg::*;

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned MW0 = (CW > SW + 1) ? CW : SW + 1;
  localparam int unsigned MW  = (MW0 > GAIN_W) ? MW0 : GAIN_W;
  localparam int unsigned PW  = MW + GAIN_W;

  localparam logic [SW:0] POS_LIM = {2'b00, {(SW-1){1'b1}}};
  localparam logic [SW:0] NEG_LIM = {2'b01, {(SW-1){1'b0}}};

  // Envelope state.
  phase_e          phase_q, phase_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic [CW-1:0]   slen, plen, vlen;
  logic            done;

  // Item registers.
  logic signed [SW-1:0] xl_q, xr_q;
  logic [CW-1:0]        pos_q, pos_d;
  gain_mode_e           mode_q, mode_d;
  logic [PW-1:0]        prod_a_q, prod_b_q;
  logic signed [SW:0]   tl_q, tr_q;
  logic signed [SW+1:0] ul_q, ur_q;
  logic [GAIN_W-1:0]    g_q;
  logic signed [SW-1:0] out_l_q, out_r_q;
  logic [GAIN_W-1:0]    out_g_q;

  // Combinational datapath signals.
  logic [MW-1:0]        op_a, op_b;
  logic [GAIN_W-1:0]    fac_a, fac_b;
  logic [PW-1:0]        mul_a, mul_b;
  logic                 pan_l_hi, pan_r_hi;
  logic [GAIN_W-1:0]    fac_l, fac_r;
  logic signed [SW-1:0] src_l, src_r;
  logic [SW-1:0]        mag_src_l, mag_src_r;
  logic [GAIN_W-1:0]    base, sq, gain_frac, gain_d;
  logic [33:0]          rnd_a34;
  logic [PW-1:0]        rnd_a, rnd_b;
  logic [SW-1:0]        t_mag;
  logic signed [SW:0]   t_signed;
  logic signed [SW+1:0] u_l_d, u_r_d, u_l_neg, u_r_neg;
  logic [SW:0]          mag_ul, mag_ur, mag_out_l, mag_out_r, neg_l, neg_r;
  logic signed [SW-1:0] sat_l, sat_r;
  logic [GAIN_W:0]      gain_sum;

  // Envelope sequencing, done once per accepted item.
  always_comb begin
    slen    = CW'(cfg_i.slope_length);
    plen    = CW'(cfg_i.plateau_length);
    vlen    = CW'(cfg_i.valley_length);
    done    = (rem_q <= CW'(1));
    phase_d = phase_q;
    rem_d   = rem_q - CW'(1);
    pos_d   = rem_q;
    mode_d  = GM_SLOPE;
    case (phase_q)
      PH_SLOPE_IN: begin
        pos_d = (slen > rem_q) ? (slen - rem_q) : '0;
        if (done) begin
          phase_d = PH_PLATEAU;
          rem_d   = plen;
        end
      end
      PH_PLATEAU: begin
        mode_d = GM_UNITY;
        if (done) begin
          if (slen != '0) begin
            phase_d = PH_SLOPE_OUT;
            rem_d   = slen;
          end else begin
            phase_d = PH_VALLEY;
            rem_d   = vlen;
          end
        end
      end
      PH_SLOPE_OUT: begin
        if (done) begin
          phase_d = PH_VALLEY;
          rem_d   = vlen;
        end
      end
      default: begin
        mode_d = GM_FLOOR;
        if (done) begin
          if (slen != '0) begin
            phase_d = PH_SLOPE_IN;
            rem_d   = slen;
          end else begin
            phase_d = PH_PLATEAU;
            rem_d   = plen;
          end
        end
      end
    endcase
  end

  // Pan factors: at or below unity the own channel is scaled, above it the
  // other channel is scaled by the excess and added to the own channel.
  always_comb begin
    pan_l_hi  = cfg_i.pan_left > PAN_W'(UNITY);
    pan_r_hi  = cfg_i.pan_right > PAN_W'(UNITY);
    fac_l     = pan_l_hi ? GAIN_W'(cfg_i.pan_left - PAN_W'(UNITY)) : cfg_i.pan_left[GAIN_W-1:0];
    fac_r     = pan_r_hi ? GAIN_W'(cfg_i.pan_right - PAN_W'(UNITY))
                         : cfg_i.pan_right[GAIN_W-1:0];
    src_l     = pan_l_hi ? xr_q : xl_q;
    src_r     = pan_r_hi ? xl_q : xr_q;
    mag_src_l = src_l[SW-1] ? SW'(-src_l) : SW'(src_l);
    mag_src_r = src_r[SW-1] ? SW'(-src_r) : SW'(src_r);
  end

  // Rounding of the registered products.
  always_comb begin
    rnd_a     = prod_a_q + PW'(HALF_LSB);
    rnd_b     = prod_b_q + PW'(HALF_LSB);
    rnd_a34   = prod_a_q[33:0] + 34'(HALF_LSB);
    base      = (prod_a_q > PW'(UNITY)) ? UNITY : prod_a_q[GAIN_W-1:0];
    sq        = rnd_a34[FRAC_W+GAIN_W-1:FRAC_W];
    gain_frac = rnd_a34[FRAC_W+GAIN_W-1:FRAC_W];
    gain_sum  = {1'b0, cfg_i.floor_gain} + {1'b0, gain_frac};
    case (mode_q)
      GM_SLOPE: gain_d = gain_sum[GAIN_W-1:0];
      GM_UNITY: gain_d = UNITY;
      default:  gain_d = cfg_i.floor_gain;
    endcase

    // First-stage channel product: the second step finishes left, the third right.
    t_mag    = rnd_b[SW+FRAC_W-1:FRAC_W];
    if (cmd_i.mul2) begin
      t_signed = src_l[SW-1] ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
    end else begin
      t_signed = src_r[SW-1] ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
    end

    u_l_d = pan_l_hi ? ((SW+2)'(xl_q) + (SW+2)'(tl_q)) : (SW+2)'(tl_q);
    u_r_d = pan_r_hi ? ((SW+2)'(xr_q) + (SW+2)'(tr_q)) : (SW+2)'(tr_q);

    u_l_neg = -ul_q;
    u_r_neg = -ur_q;
    mag_ul  = ul_q[SW+1] ? u_l_neg[SW:0] : ul_q[SW:0];
    mag_ur  = ur_q[SW+1] ? u_r_neg[SW:0] : ur_q[SW:0];
  end

  // Operand selection for the two shared multipliers.
  always_comb begin
    op_a  = '0;
    fac_a = '0;
    op_b  = '0;
    fac_b = '0;
    if (cmd_i.mul1) begin
      op_a  = MW'(pos_q);
      fac_a = cfg_i.slope_recip;
      op_b  = MW'(mag_src_l);
      fac_b = fac_l;
    end else if (cmd_i.mul2) begin
      op_a  = MW'(base);
      fac_a = base;
      op_b  = MW'(mag_src_r);
      fac_b = fac_r;
    end else if (cmd_i.mul3) begin
      op_a  = MW'(sq);
      fac_a = UNITY - cfg_i.floor_gain;
    end else if (cmd_i.mul4) begin
      op_a  = MW'(mag_ul);
      fac_a = g_q;
      op_b  = MW'(mag_ur);
      fac_b = g_q;
    end
    mul_a = PW'(op_a) * PW'(fac_a);
    mul_b = PW'(op_b) * PW'(fac_b);
  end

  // Final rounding and saturation.
  always_comb begin
    mag_out_l = rnd_a[SW+FRAC_W:FRAC_W];
    mag_out_r = rnd_b[SW+FRAC_W:FRAC_W];
    neg_l     = -mag_out_l;
    neg_r     = -mag_out_r;
    if (!ul_q[SW+1]) begin
      sat_l = (mag_out_l > POS_LIM) ? POS_LIM[SW-1:0] : mag_out_l[SW-1:0];
    end else begin
      sat_l = (mag_out_l > NEG_LIM) ? NEG_LIM[SW-1:0] : neg_l[SW-1:0];
    end
    if (!ur_q[SW+1]) begin
      sat_r = (mag_out_r > POS_LIM) ? POS_LIM[SW-1:0] : mag_out_r[SW-1:0];
    end else begin
      sat_r = (mag_out_r > NEG_LIM) ? NEG_LIM[SW-1:0] : neg_r[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VALLEY;
      rem_q   <= '0;
    end else if (cmd_i.capture) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      xl_q   <= left_sample_i;
      xr_q   <= right_sample_i;
      pos_q  <= pos_d;
      mode_q <= mode_d;
    end
    if (cmd_i.mul1 || cmd_i.mul2 || cmd_i.mul3 || cmd_i.mul4) begin
      prod_a_q <= mul_a;
    end
    if (cmd_i.mul1 || cmd_i.mul2 || cmd_i.mul4) begin
      prod_b_q <= mul_b;
    end
    if (cmd_i.mul2) begin
      tl_q <= t_signed;
    end
    if (cmd_i.mul3) begin
      tr_q <= t_signed;
      ul_q <= u_l_d;
    end
    if (cmd_i.gain) begin
      g_q  <= gain_d;
      ur_q <= u_r_d;
    end
    if (cmd_i.finish) begin
      out_l_q <= sat_l;
      out_r_q <= sat_r;
      out_g_q <= g_q;
    end
  end

  assign left_out_o      = out_l_q;
  assign right_out_o     = out_r_q;
  assign envelope_gain_o = out_g_q;

endmodule

// File: rtl/core/gated_envelope_panner.sv
// Top level of the gated envelope panner: register file, controller and datapath.
// Item flow: each item passes through four multiply steps on the two shared
// multipliers, the gain step and the output write, which waits while a result is
// held; the next item is taken in the cycle that the previous result enters the
// output register.
// Reset: registers return to their defaults, the envelope sits in the valley
// with a zero count, and no result is pending.
module gated_envelope_panner #(
  parameter int unsigned SAMPLE_WIDTH = gep_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = gep_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [gep_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gep_pkg::CFG_W-1:0]       cfg_data_i,
  // Input channel: one stereo sample pair per item.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  left_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  right_sample_i,
  // Output channel: panned, gated samples and the envelope gain used.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]  left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]  right_out_o,
  output logic [gep_pkg::GAIN_W-1:0]      envelope_gain_o
);
  import gep_pkg::*;

  // Clamped register contents, shared by the datapath.
  cfg_t    cfg;
  // Per-step commands from the sequencer.
  dp_cmd_t cmd;

  // The register file clamps gains and pans as they are written, so the
  // datapath never sees an out-of-range value.
  gep_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The controller walks each item through capture, three multiply steps for
  // the envelope slope (position times reciprocal, square, scale to floor),
  // a gain step and the final channel multiplies. The output register lets a
  // finished result wait while the next item is taken.
  gep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath advances the envelope phase when an item is captured and
  // computes the pan products for both channels alongside the slope gain.
  gep_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .left_out_o      (left_out_o),
    .right_out_o     (right_out_o),
    .envelope_gain_o (envelope_gain_o)
  );

endmodule
